[design/afr_pkg.sv]
`timescale 1ns / 1ps

package afr_pkg;

  localparam int unsigned MAX_PAYLOAD = 251;

  localparam logic [7:0] SYNC_CHAR   = 8'hAA;
  localparam logic [7:0] IDLE_LENGTH = 8'hFC;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_WRONG_ADR = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  // frame control state, cleared by reset
  typedef struct packed {
    logic       sync_seen;
    logic [7:0] position;
    logic [7:0] frame_length;
    logic [7:0] running_sum;
  } ctl_t;

  // frame header stores, only read after being written in the current frame
  typedef struct packed {
    logic [7:0] frame_address;
    logic [7:0] frame_command;
    logic [7:0] frame_first_data;
  } hdr_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] first_data;
  } res_t;

endpackage

[design/afr_decode.sv]
`timescale 1ns / 1ps

module afr_decode (
  input  afr_pkg::ctl_t ctl,
  input  afr_pkg::hdr_t hdr,
  input  logic [7:0]    rx_byte,
  input  logic          ninth_bit,
  input  logic          frame_error,
  input  logic          overrun,
  input  logic [7:0]    device_address,
  output afr_pkg::ctl_t ctl_next,
  output afr_pkg::hdr_t hdr_next,
  output logic          res_valid,
  output afr_pkg::res_t res
);
  import afr_pkg::*;

  logic [7:0] pos_inc;
  logic [7:0] len_eff;
  logic [7:0] first_eff;
  logic [8:0] end_pos;

  always_comb begin
    ctl_next  = ctl;
    hdr_next  = hdr;
    res_valid = 1'b0;
    res       = '{status: ST_GOOD, command: hdr.frame_command,
                  payload_length: ctl.frame_length, first_data: hdr.frame_first_data};
    pos_inc   = ctl.position + 8'd1;
    len_eff   = ctl.frame_length;
    first_eff = hdr.frame_first_data;
    end_pos   = {1'b0, ctl.frame_length} + 9'd4;

    if (!ninth_bit && !frame_error) begin
      // clean sync character restarts the frame, even with overrun
      ctl_next.sync_seen    = (rx_byte == SYNC_CHAR);
      ctl_next.position     = '0;
      ctl_next.frame_length = IDLE_LENGTH;
      ctl_next.running_sum  = '0;
    end else if (!ninth_bit || frame_error || overrun || !ctl.sync_seen) begin
      ctl_next.sync_seen    = 1'b0;
      ctl_next.position     = '0;
      ctl_next.frame_length = IDLE_LENGTH;
    end else begin
      ctl_next.position = pos_inc;
      if (pos_inc == 8'd1) hdr_next.frame_address = rx_byte;
      if (pos_inc == 8'd2) hdr_next.frame_command = rx_byte;
      if (pos_inc == 8'd3) len_eff = rx_byte;
      if (pos_inc == 8'd4) first_eff = rx_byte;
      hdr_next.frame_first_data = first_eff;
      end_pos = {1'b0, len_eff} + 9'd4;

      if (pos_inc == 8'd3 && rx_byte > 8'(MAX_PAYLOAD)) begin
        res_valid             = 1'b1;
        res.status            = ST_TOO_LONG;
        res.payload_length    = rx_byte;
        res.first_data        = '0;
        ctl_next.sync_seen    = 1'b0;
        ctl_next.position     = '0;
        ctl_next.frame_length = IDLE_LENGTH;
      end else if ({1'b0, pos_inc} == end_pos) begin
        // checksum byte
        res_valid          = 1'b1;
        res.payload_length = len_eff;
        res.first_data     = first_eff;
        if (hdr.frame_address != device_address) begin
          res.status = ST_WRONG_ADR;
        end else if (ctl.running_sum == rx_byte) begin
          res.status = ST_GOOD;
        end else begin
          res.status = ST_BAD_SUM;
        end
        ctl_next.sync_seen    = 1'b0;
        ctl_next.position     = '0;
        ctl_next.frame_length = IDLE_LENGTH;
      end else begin
        ctl_next.frame_length = len_eff;
        ctl_next.running_sum  = ctl.running_sum + rx_byte;
      end
    end
  end

endmodule

[design/addressed_frame_receiver.sv]
`timescale 1ns / 1ps

// channel   valid        stall        payload
// rx        rx_valid     rx_stall     rx_byte, ninth_bit, frame_error, overrun
// frame     frame_valid  frame_stall  status, command, payload_length, first_data
// config    device_address_we         device_address_data
//
// One character per cycle unless rx_stall is raised. A character is held in the
// input register, decoded against the frame state, and any result lands in the
// output register. rst is synchronous and clears frame state, the address
// register and both valid flags. A stalled result holds the decode stage; rx
// keeps being taken while that stage is free.

module addressed_frame_receiver (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rx_valid,
  output logic                 rx_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 ninth_bit,
  input  logic                 frame_error,
  input  logic                 overrun,
  output logic                 frame_valid,
  input  logic                 frame_stall,
  output afr_pkg::status_t     status,
  output logic [7:0]           command,
  output logic [7:0]           payload_length,
  output logic [7:0]           first_data,
  input  logic                 device_address_we,
  input  logic [7:0]           device_address_data
);
  import afr_pkg::*;

  logic [7:0] device_address;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_ninth;
  logic       s1_ferr;
  logic       s1_ovr;

  ctl_t ctl;
  ctl_t ctl_next;
  hdr_t hdr;
  hdr_t hdr_next;
  res_t res_next;
  res_t res;
  logic res_valid_next;

  logic out_free;
  logic go;
  logic rx_take;

  assign out_free = !frame_valid || !frame_stall;
  assign go       = s1_valid && out_free;
  assign rx_stall = s1_valid && !out_free;
  assign rx_take  = rx_valid && !rx_stall;

  afr_decode u_decode (
    .ctl            (ctl),
    .hdr            (hdr),
    .rx_byte        (s1_byte),
    .ninth_bit      (s1_ninth),
    .frame_error    (s1_ferr),
    .overrun        (s1_ovr),
    .device_address (device_address),
    .ctl_next       (ctl_next),
    .hdr_next       (hdr_next),
    .res_valid      (res_valid_next),
    .res            (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= '0;
    end else if (device_address_we) begin
      device_address <= device_address_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rx_stall) begin
      s1_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      s1_byte  <= rx_byte;
      s1_ninth <= ninth_bit;
      s1_ferr  <= frame_error;
      s1_ovr   <= overrun;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '{sync_seen: 1'b0, position: 8'd0, frame_length: IDLE_LENGTH,
               running_sum: 8'd0};
    end else if (go) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hdr <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (out_free) begin
      frame_valid <= go && res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid_next) begin
      res <= res_next;
    end
  end

  assign status         = res.status;
  assign command        = res.command;
  assign payload_length = res.payload_length;
  assign first_data     = res.first_data;

endmodule

[tb/afr_frame_check.sv]
`timescale 1ns / 1ps

module afr_frame_check (
  input  logic             clk,
  input  logic             rst,
  input  logic             rx_valid,
  input  logic             rx_stall,
  input  logic [7:0]       rx_byte,
  input  logic             ninth_bit,
  input  logic             frame_error,
  input  logic             overrun,
  input  logic             frame_valid,
  input  logic             frame_stall,
  input  afr_pkg::status_t status,
  input  logic [7:0]       command,
  input  logic [7:0]       payload_length,
  input  logic [7:0]       first_data,
  input  logic             device_address_we,
  input  logic [7:0]       device_address_data,
  output int               mismatches,
  output int               pending,
  output int               reports_seen
);
  import afr_pkg::*;

  // receiver state as the block should hold it
  logic [7:0] my_address;
  logic       in_sync;
  logic [7:0] pos;
  logic [7:0] flen;
  logic [7:0] csum;
  logic [7:0] hdr_addr;
  logic [7:0] hdr_cmd;
  logic [7:0] hdr_first;

  res_t due_reports[$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    reports_seen = 0;
  end

  task drop_frame();
    in_sync = 1'b0;
    pos     = 8'd0;
    flen    = IDLE_LENGTH;
  endtask

  task decode_char(input logic [7:0] ch, input logic nb, input logic fe, input logic ov,
                   output bit hit, output res_t r);
    bit too_long;
    hit      = 1'b0;
    too_long = 1'b0;
    r        = '0;
    if (!nb && !fe) begin
      // any clean sync-class char restarts; only 0xAA arms the frame
      in_sync = (ch == SYNC_CHAR);
      pos     = 8'd0;
      flen    = IDLE_LENGTH;
      csum    = 8'd0;
    end else if (!nb || fe || ov || !in_sync) begin
      drop_frame();
    end else begin
      pos = pos + 8'd1;
      if (pos == 8'd1) hdr_addr = ch;
      if (pos == 8'd2) hdr_cmd = ch;
      if (pos == 8'd3) begin
        if (ch > MAX_PAYLOAD) begin
          too_long         = 1'b1;
          hit              = 1'b1;
          r.status         = ST_TOO_LONG;
          r.command        = hdr_cmd;
          r.payload_length = ch;
          r.first_data     = 8'd0;
          drop_frame();
        end else begin
          flen = ch;
        end
      end
      if (!too_long) begin
        if (pos == 8'd4) hdr_first = ch;
        if (int'(pos) == int'(flen) + 4) begin
          hit = 1'b1;
          if (hdr_addr != my_address)
            r.status = ST_WRONG_ADR;
          else if (csum == ch)
            r.status = ST_GOOD;
          else
            r.status = ST_BAD_SUM;
          r.command        = hdr_cmd;
          r.payload_length = flen;
          r.first_data     = hdr_first;
          drop_frame();
        end else begin
          csum = csum + ch;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bit   hit;
    res_t r;
    res_t want;
    if (rst) begin
      my_address = 8'd0;
      csum       = 8'd0;
      hdr_addr   = 8'd0;
      hdr_cmd    = 8'd0;
      hdr_first  = 8'd0;
      drop_frame();
      due_reports.delete();
    end else begin
      if (device_address_we) my_address = device_address_data;
      if (rx_valid && !rx_stall) begin
        decode_char(rx_byte, ninth_bit, frame_error, overrun, hit, r);
        if (hit) due_reports.push_back(r);
      end
      if (frame_valid && !frame_stall) begin
        reports_seen++;
        if (due_reports.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: report with none due: st %0d cmd %02h len %02h first %02h",
                     $realtime, status, command, payload_length, first_data);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          if (status !== want.status || command !== want.command ||
              payload_length !== want.payload_length || first_data !== want.first_data) begin
            if (mismatches < 10)
              $display({"%0t: want st %0d cmd %02h len %02h first %02h,",
                        " got st %0d cmd %02h len %02h first %02h"},
                       $realtime, want.status, want.command, want.payload_length,
                       want.first_data, status, command, payload_length, first_data);
            mismatches++;
          end
        end
      end
    end
    pending = due_reports.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import afr_pkg::*;

  localparam int LIMIT = 400000;

  logic       clk;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       ninth_bit = 1'b0;
  logic       frame_error = 1'b0;
  logic       overrun = 1'b0;
  logic       frame_valid;
  logic       frame_stall = 1'b0;
  status_t    status;
  logic [7:0] command;
  logic [7:0] payload_length;
  logic [7:0] first_data;
  logic       device_address_we = 1'b0;
  logic [7:0] device_address_data = 8'd0;

  int mismatches;
  int pending;
  int reports_seen;
  int sent = 0;
  int burst_left = 0;
  int addr_writes = 0;
  int cycles = 0;
  logic [7:0] cur_addr = 8'd0;

  addressed_frame_receiver dut (
    .clk                 (clk),
    .rst                 (rst),
    .rx_valid            (rx_valid),
    .rx_stall            (rx_stall),
    .rx_byte             (rx_byte),
    .ninth_bit           (ninth_bit),
    .frame_error         (frame_error),
    .overrun             (overrun),
    .frame_valid         (frame_valid),
    .frame_stall         (frame_stall),
    .status              (status),
    .command             (command),
    .payload_length      (payload_length),
    .first_data          (first_data),
    .device_address_we   (device_address_we),
    .device_address_data (device_address_data)
  );

  afr_frame_check check (
    .clk                 (clk),
    .rst                 (rst),
    .rx_valid            (rx_valid),
    .rx_stall            (rx_stall),
    .rx_byte             (rx_byte),
    .ninth_bit           (ninth_bit),
    .frame_error         (frame_error),
    .overrun             (overrun),
    .frame_valid         (frame_valid),
    .frame_stall         (frame_stall),
    .status              (status),
    .command             (command),
    .payload_length      (payload_length),
    .first_data          (first_data),
    .device_address_we   (device_address_we),
    .device_address_data (device_address_data),
    .mismatches          (mismatches),
    .pending             (pending),
    .reports_seen        (reports_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("addressed_frame_receiver: mismatch");
      $finish;
    end
  end

  // receiver side: changing stall modes, plus a long hold-off now and then
  initial begin : stall_gen
    int mode;
    int left;
    int hold_left;
    int cyc;
    mode      = 0;
    left      = 0;
    hold_left = 0;
    cyc       = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 1500 == 400) hold_left = 120;
      if (hold_left > 0) begin
        hold_left--;
        frame_stall <= 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(30, 200);
        end
        left--;
        case (mode)
          0: frame_stall <= 1'b0;
          1: frame_stall <= ($urandom_range(0, 3) == 0);
          2: frame_stall <= ($urandom_range(0, 3) != 0);
          default: frame_stall <= ~frame_stall;
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] ch, input logic nb, input logic fe,
                           input logic ov);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    rx_byte     <= ch;
    ninth_bit   <= nb;
    frame_error <= fe;
    overrun     <= ov;
    rx_valid    <= 1'b1;
    do @(posedge clk); while (rx_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_glitch();
    case ($urandom_range(0, 2))
      0: send_char(8'($urandom), 1'($urandom), 1'b1, 1'($urandom));
      1: send_char(8'($urandom), 1'b1, 1'b0, 1'b1);
      default: send_char(8'($urandom), 1'b0, 1'b0, 1'($urandom));
    endcase
  endtask

  // sync, address, command, length, data, checksum; break_at replaces one char
  task automatic send_frame(input logic [7:0] adr, input logic [7:0] cmd,
                            input logic [7:0] len, input bit bad_sum,
                            input int break_at, input bit sync_ov);
    logic [7:0] sum;
    logic [7:0] body[$];
    int i;
    body = {adr, cmd, len};
    sum  = adr + cmd + len;
    if (len <= MAX_PAYLOAD) begin
      for (i = 0; i < len; i++) begin
        body.push_back(8'($urandom));
        sum = sum + body[$];
      end
      body.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
    if (break_at == 0) send_glitch();
    else send_char(SYNC_CHAR, 1'b0, 1'b0, sync_ov);
    for (i = 0; i < body.size(); i++) begin
      if (break_at == i + 1) send_glitch();
      else send_char(body[i], 1'b1, 1'b0, 1'b0);
    end
  endtask

  // only once the receiver has drained, with a margin for no-report chars in flight
  task automatic set_address(input logic [7:0] v);
    rx_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    device_address_we   <= 1'b1;
    device_address_data <= v;
    @(negedge clk);
    device_address_we <= 1'b0;
    cur_addr = v;
    addr_writes++;
  endtask

  initial begin : stimulus
    int ph;
    int pick;
    int r;
    int goal;
    logic [7:0] len;
    logic [7:0] adr;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_address(8'hFF);
    send_frame(8'hFF, 8'h00, 8'h00, 1'b0, -1, 1'b1);  // good, empty, sync with overrun
    send_frame(8'h12, 8'hFF, 8'h01, 1'b0, -1, 1'b0);  // wrong address
    send_frame(8'hFF, 8'h3C, 8'h01, 1'b1, -1, 1'b0);  // bad checksum
    send_frame(8'hFF, 8'h01, 8'hFF, 1'b0, -1, 1'b0);  // length too large
    send_char(8'h55, 1'b0, 1'b0, 1'b0);                // sync without 0xAA
    send_char(8'h11, 1'b1, 1'b0, 1'b0);                // body with no sync
    send_char(8'hAA, 1'b0, 1'b1, 1'b1);                // framing error on sync
    send_char(8'h00, 1'b1, 1'b0, 1'b0);

    for (ph = 0; ph < 6; ph++) begin
      set_address(ph == 0 ? 8'h00 : ph == 3 ? 8'hFF : 8'($urandom));
      if (ph == 0) send_frame(cur_addr, 8'($urandom), 8'(MAX_PAYLOAD), 1'b0, -1, 1'b0);
      goal = 25 + (ph + 1) * 215;
      while (sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          repeat ($urandom_range(1, 4))
            send_char(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 80)      len = 8'($urandom_range(0, 6));
          else if (r < 93) len = 8'($urandom_range(7, 30));
          else if (r < 98) len = 8'($urandom_range(252, 255));
          else             len = 8'($urandom_range(100, MAX_PAYLOAD));
          adr = ($urandom_range(0, 3) != 0) ? cur_addr : 8'($urandom);
          send_frame(adr, 8'($urandom), len, $urandom_range(0, 4) == 0,
                     pick < 30 ? int'($urandom_range(0, int'(len) + 4)) : -1,
                     $urandom_range(0, 7) == 0);
        end
      end
    end

    rx_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("covered %0d chars, %0d frame reports, %0d address settings incl. 00 and FF,",
             sent, reports_seen, addr_writes);
    $display("clean, broken and noisy frames, lengths 0 to 255, long receiver hold-offs");
    if (mismatches == 0 && pending == 0)
      $display("addressed_frame_receiver: match");
    else
      $display("addressed_frame_receiver: mismatch");
    $finish;
  end

endmodule

[sim.f]
design/afr_pkg.sv
design/afr_decode.sv
design/addressed_frame_receiver.sv
tb/afr_frame_check.sv
tb/tb.sv
